>>> hdl/pjb_pkg.sv
// pjb_pkg: types and constants for the packet jitter buffer
// no dependencies
package pjb_pkg;

    localparam int SEQ_W    = 16;
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int CAP_W    = 3;
    localparam int DEAD_W   = 8;

    localparam logic [SEQ_W-1:0]  OLD_SPAN      = 16'h8000;
    localparam logic [CAP_W-1:0]  CAP_RESET     = 3'd6;
    localparam logic [DEAD_W-1:0] DEAD_RESET    = 8'd4;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_CAPACITY = 1'b0,
        CFG_DEAD     = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_OLD     = 3'd1,
        ST_DUP     = 3'd2,
        ST_NOTHING = 3'd3,
        ST_GOOD    = 3'd4,
        ST_LOST    = 3'd5
    } t_status;

    typedef struct packed {
        t_cmd                command;
        logic [SEQ_W-1:0]    sequence_number;
        logic [HANDLE_W-1:0] packet_handle;
        logic [TIME_W-1:0]   now_seconds;
    } t_jb_in;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] out_handle;
        logic                window_restarted;
    } t_jb_out;

endpackage

>>> hdl/pjb_ram.sv
// pjb_ram: generic single write port, single read port ram with registered read
// no dependencies; read returns the contents from before a same-cycle write
module pjb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/packet_jitter_buffer_top.sv
// an accepted item waits in the input register; its result is then written to the result register
// throughput: one insert or remove per cycle while the result register is empty or being taken;
// the state update is combinational. input register and result register decouple the two channels, so
// stalls on the output do not block a waiting item until both registers are full
// reset (synchronous, active low) clears the window, the full bits and the config registers
// to their defaults; the handle store is not cleared
module packet_jitter_buffer_top
    import pjb_pkg::*;
#(
    parameter int RING_SLOTS  = 8,
    parameter int HANDLE_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_jb_in            i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_jb_out           o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  t_cfg_index        i_cfg_index,
    input  logic [DEAD_W-1:0] i_cfg_data
);

    localparam int SLOT_W = $clog2(RING_SLOTS);
    localparam int HW     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    logic                r_in_valid;
    t_jb_in              r_in;
    logic                r_out_valid;
    t_jb_out             r_out;
    logic [CAP_W-1:0]    r_cap;
    logic [DEAD_W-1:0]   r_dead;
    logic [SEQ_W-1:0]    r_bottom, n_bottom;
    logic [SEQ_W-1:0]    r_top, n_top;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [RING_SLOTS-1:0] r_full, n_full;
    logic                r_byp;
    logic [HW-1:0]       r_byp_data;

    logic                proc_fire;
    t_jb_out             n_out;
    logic                we;
    logic [SLOT_W-1:0]   waddr;
    logic [SLOT_W-1:0]   raddr;
    logic [HW-1:0]       ram_q;
    logic [HW-1:0]       bot_handle;

    logic [SEQ_W-1:0]    d;
    logic [SEQ_W-1:0]    span;
    logic [SLOT_W-1:0]   islot;
    logic [SLOT_W-1:0]   bslot;
    logic                dead;

    assign proc_fire   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc_fire;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign d     = r_in.sequence_number - r_bottom;
    assign span  = r_top - r_bottom;
    assign islot = r_in.sequence_number[SLOT_W-1:0];
    assign bslot = r_bottom[SLOT_W-1:0];
    assign dead  = ({1'b0, r_last} + {{(TIME_W+1-DEAD_W){1'b0}}, r_dead})
                   <= {1'b0, r_in.now_seconds};
    assign bot_handle = r_byp ? r_byp_data : ram_q;

    always_comb begin
        n_bottom = r_bottom;
        n_top    = r_top;
        n_last   = r_last;
        n_full   = r_full;
        we       = 1'b0;
        n_out.status           = ST_NOTHING;
        n_out.out_handle       = '0;
        n_out.window_restarted = 1'b0;
        if (proc_fire) begin
            case (r_in.command)
                CMD_INSERT: begin
                    if (!dead && (d > OLD_SPAN)) begin
                        n_out.status = ST_OLD;
                    end else if ({1'b0, d} > (SEQ_W+1)'(RING_SLOTS)) begin
                        n_full        = '0;
                        n_full[islot] = 1'b1;
                        we            = 1'b1;
                        n_bottom = r_in.sequence_number - {{(SEQ_W-CAP_W){1'b0}}, r_cap};
                        n_top    = r_in.sequence_number + 16'd1;
                        n_last   = r_in.now_seconds;
                        n_out.status           = ST_QUEUED;
                        n_out.window_restarted = 1'b1;
                    end else if (r_full[islot]) begin
                        n_out.status = ST_DUP;
                    end else begin
                        n_full[islot] = 1'b1;
                        we            = 1'b1;
                        if (d >= span) begin
                            n_top = r_in.sequence_number + 16'd1;
                        end
                        n_last       = r_in.now_seconds;
                        n_out.status = ST_QUEUED;
                    end
                end
                CMD_REMOVE: begin
                    if (r_top != r_bottom) begin
                        if (r_full[bslot]) begin
                            n_out.out_handle = HANDLE_W'(bot_handle);
                            n_full[bslot]    = 1'b0;
                            n_bottom         = r_bottom + 16'd1;
                            n_out.status     = ST_GOOD;
                        end else if (span > {{(SEQ_W-CAP_W){1'b0}}, r_cap}) begin
                            n_bottom     = r_bottom + 16'd1;
                            n_out.status = ST_LOST;
                        end
                    end
                end
                default: begin
                    n_out.status = ST_NOTHING;
                end
            endcase
        end
    end

    assign waddr = islot;
    assign raddr = n_bottom[SLOT_W-1:0];

    pjb_ram #(
        .WIDTH (HW),
        .DEPTH (RING_SLOTS)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_in.packet_handle[HW-1:0]),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
            r_dead      <= DEAD_RESET;
            r_bottom    <= '0;
            r_top       <= '0;
            r_last      <= '0;
            r_full      <= '0;
            r_byp       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap  <= i_cfg_data[CAP_W-1:0];
                    CFG_DEAD:     r_dead <= i_cfg_data;
                    default:      r_cap  <= r_cap;
                endcase
            end
            r_bottom <= n_bottom;
            r_top    <= n_top;
            r_last   <= n_last;
            r_full   <= n_full;
            r_byp    <= we && (waddr == raddr);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (proc_fire) begin
            r_out <= n_out;
        end
        r_byp_data <= r_in.packet_handle[HW-1:0];
    end

`ifndef SYNTHESIS
    a_good_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && (n_out.status == ST_GOOD) |=> r_bottom == $past(r_bottom) + 16'd1)
        else $error("bottom did not advance after a good remove");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !proc_fire |=> r_in_valid && $stable(r_in))
        else $error("input register lost a waiting item");

    a_restart_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.window_restarted |-> o_out_item.status == ST_QUEUED)
        else $error("window restart flagged on a non-queued result");

    a_handle_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.out_handle != '0) |-> o_out_item.status == ST_GOOD)
        else $error("handle reported on a result that is not good");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_full == '0) && (r_top == r_bottom) && !r_out_valid)
        else $error("reset did not clear the window");
`endif

endmodule

>>> tb/packet_jitter_buffer_top_tb.sv
// packet_jitter_buffer_top_tb: self-checking testbench for the packet jitter buffer
// predicts every result in a scoreboard class and drives both item channels and config port
// depends on pjb_pkg and packet_jitter_buffer_top
`timescale 1ns / 100ps

module packet_jitter_buffer_top_tb
    import pjb_pkg::*;
();

    localparam int RING        = 8;
    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 6;
    localparam int HOLD_CYCLES = 120;

    class jb_scoreboard;
        logic [CAP_W-1:0]    capacity;
        logic [DEAD_W-1:0]   dead_time;
        logic [SEQ_W-1:0]    bottom;
        logic [SEQ_W-1:0]    top;
        logic [TIME_W-1:0]   last_insert;
        bit                  slot_full [RING];
        logic [HANDLE_W-1:0] slot_handle [RING];
        t_jb_out             awaited [$];
        int                  errors;

        function new();
            capacity    = CAP_RESET;
            dead_time   = DEAD_RESET;
            bottom      = '0;
            top         = '0;
            last_insert = '0;
            errors      = 0;
            foreach (slot_full[i]) begin
                slot_full[i]   = 1'b0;
                slot_handle[i] = '0;
            end
        endfunction

        function void write_reg(t_cfg_index idx, logic [DEAD_W-1:0] data);
            if (idx == CFG_CAPACITY) begin
                capacity = data[CAP_W-1:0];
            end else begin
                dead_time = data;
            end
        endfunction

        // advance the window state by one accepted item and queue its result
        function void note_input(t_jb_in it);
            t_jb_out            want;
            logic [SEQ_W-1:0]   gap;
            logic [SEQ_W-1:0]   span;
            logic [TIME_W:0]    due;
            int                 slot;
            want.status           = ST_NOTHING;
            want.out_handle       = '0;
            want.window_restarted = 1'b0;
            span = top - bottom;
            if (it.command == CMD_INSERT) begin
                gap  = it.sequence_number - bottom;
                slot = it.sequence_number % RING;
                due  = {1'b0, last_insert} + {{(TIME_W+1-DEAD_W){1'b0}}, dead_time};
                if (due > {1'b0, it.now_seconds} && gap > OLD_SPAN) begin
                    want.status = ST_OLD;
                end else if (gap > RING) begin
                    foreach (slot_full[i]) slot_full[i] = 1'b0;
                    bottom                = it.sequence_number - SEQ_W'(capacity);
                    slot_full[slot]       = 1'b1;
                    slot_handle[slot]     = it.packet_handle;
                    top                   = it.sequence_number + 16'd1;
                    last_insert           = it.now_seconds;
                    want.status           = ST_QUEUED;
                    want.window_restarted = 1'b1;
                end else if (slot_full[slot]) begin
                    want.status = ST_DUP;
                end else begin
                    slot_full[slot]   = 1'b1;
                    slot_handle[slot] = it.packet_handle;
                    if (gap >= span) top = it.sequence_number + 16'd1;
                    last_insert = it.now_seconds;
                    want.status = ST_QUEUED;
                end
            end else if (top != bottom) begin
                slot = bottom % RING;
                if (slot_full[slot]) begin
                    want.out_handle = slot_handle[slot];
                    slot_full[slot] = 1'b0;
                    bottom          = bottom + 16'd1;
                    want.status     = ST_GOOD;
                end else if (span > SEQ_W'(capacity)) begin
                    bottom      = bottom + 16'd1;
                    want.status = ST_LOST;
                end
            end
            awaited.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_jb_out got);
            t_jb_out want;
            if (awaited.size() == 0) begin
                report_mismatch("result with no item outstanding");
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.out_handle !== want.out_handle)
                report_mismatch($sformatf("out_handle got %h want %h",
                                          got.out_handle, want.out_handle));
            if (got.window_restarted !== want.window_restarted)
                report_mismatch($sformatf("window_restarted got %b want %b",
                                          got.window_restarted, want.window_restarted));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_jb_in            i_in_item;
    logic              o_out_valid;
    logic              i_out_ready;
    t_jb_out           o_out_item;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    t_cfg_index        i_cfg_index;
    logic [DEAD_W-1:0] i_cfg_data;

    jb_scoreboard      sb;
    int                cycle_count = 0;
    int                stall_pct   = 0;
    int                hold_left   = 0;
    logic [SEQ_W-1:0]  stream_seq;
    logic [TIME_W-1:0] clock_now;

    int phase_cap   [NUM_PHASES] = '{7, 1, 4, 6, 3, 5};
    int phase_dead  [NUM_PHASES] = '{255, 0, 4, 9, 4, 2};
    int phase_idle  [NUM_PHASES] = '{0, 56, 0, 36, 0, 0};
    int phase_stall [NUM_PHASES] = '{0, 0, 56, 36, 0, 0};
    int phase_items [NUM_PHASES] = '{140, 140, 140, 140, 150, 140};
    bit phase_hold  [NUM_PHASES] = '{0, 0, 0, 0, 1, 0};

    packet_jitter_buffer_top #(
        .RING_SLOTS  (RING),
        .HANDLE_BITS (HANDLE_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // handshake monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_item);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_item);
        end
    end

    // receiver with random stalls and an optional long hold-off
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input t_jb_in it, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_directed(input t_cmd cmd, input logic [SEQ_W-1:0] seq,
                                 input logic [HANDLE_W-1:0] handle,
                                 input logic [TIME_W-1:0] now);
        t_jb_in it;
        it.command         = cmd;
        it.sequence_number = seq;
        it.packet_handle   = handle;
        it.now_seconds     = now;
        send_item(it, 0);
    endtask

    task automatic configure(input int cap, input int dead);
        logic [DEAD_W-1:0] cap_word;
        cap_word             = DEAD_W'($urandom);
        cap_word[CAP_W-1:0]  = CAP_W'(cap);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_data  <= cap_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_DEAD;
        i_cfg_data  <= DEAD_W'(dead);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // removes, plus inserts from a mostly in-order stream with some reordering, old packets and jumps
    function automatic t_jb_in next_random_item();
        t_jb_in it;
        int     pick;
        int     offset;
        pick               = $urandom_range(99);
        it.command         = CMD_INSERT;
        it.sequence_number = SEQ_W'($urandom);
        it.packet_handle   = HANDLE_W'($urandom);
        if ($urandom_range(39) == 0) begin
            clock_now = $urandom;
        end else if ($urandom_range(9) == 0) begin
            clock_now = clock_now + $urandom_range(300, 2);
        end else begin
            clock_now = clock_now + $urandom_range(1);
        end
        it.now_seconds = clock_now;
        if (pick < 44) begin
            it.command = CMD_REMOVE;
        end else if (pick < 92) begin
            offset = ($urandom_range(9) < 7) ? 0 : int'($urandom_range(5)) - 3;
            it.sequence_number = SEQ_W'(int'(stream_seq) + offset);
            if (offset >= 0) stream_seq = SEQ_W'(int'(stream_seq) + offset + 1);
        end else if (pick < 96) begin
            it.sequence_number = stream_seq - SEQ_W'($urandom_range(32000, 20));
        end else begin
            stream_seq = it.sequence_number + 16'd1;
        end
        return it;
    endfunction

    initial begin
        sb          = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_CAPACITY;
        i_cfg_data  <= '0;
        stream_seq  = SEQ_W'($urandom);
        clock_now   = $urandom_range(1000);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items at reset config
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd0);
        send_directed(CMD_INSERT, 16'h0000, 16'hFFFF, 32'd0);
        send_directed(CMD_INSERT, 16'h0000, 16'h1234, 32'd0);
        send_directed(CMD_INSERT, 16'h0002, 16'h0000, 32'd1);
        send_directed(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 32'd1);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd1);
        send_directed(CMD_INSERT, 16'hFFF0, 16'h0001, 32'd2);
        send_directed(CMD_INSERT, 16'h0008, 16'h7777, 32'd3);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd3);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd3);
        send_directed(CMD_INSERT, 16'h8003, 16'h8001, 32'd3);
        send_directed(CMD_INSERT, 16'h7FFC, 16'h4242, 32'd3);
        send_directed(CMD_INSERT, 16'h7FFC, 16'h4242, 32'd7);
        send_directed(CMD_INSERT, 16'h7FFE, 16'h0F0F, 32'd7);
        send_directed(CMD_INSERT, 16'h7FF6, 16'hF0F0, 32'd7);
        send_directed(CMD_INSERT, 16'hFFFF, 16'hAAAA, 32'hFFFF_FFFF);
        send_directed(CMD_INSERT, 16'hFFFA, 16'h5555, 32'hFFFF_FFFF);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        i_in_valid <= 1'b0;

        // capacity zero: a missing packet is lost at once
        drain();
        configure(0, 0);
        send_directed(CMD_INSERT, 16'h0001, 16'h3C3C, 32'd0);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd0);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd0);
        send_directed(CMD_INSERT, 16'hFFFF, 16'hC3C3, 32'd0);
        send_directed(CMD_REMOVE, 16'h0000, 16'h0000, 32'd0);
        i_in_valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            configure(phase_cap[p], phase_dead[p]);
            stall_pct = phase_stall[p];
            if (phase_hold[p]) hold_left = HOLD_CYCLES;
            repeat (phase_items[p]) send_item(next_random_item(), phase_idle[p]);
            i_in_valid <= 1'b0;
        end

        drain();
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
